FILE: rtl/strapped_output_latch_window_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the strapped output latch window
// Shared helpers for concurrent checks, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef STRAPPED_OUTPUT_LATCH_WINDOW_TOP_ASSERT_SVH
`define STRAPPED_OUTPUT_LATCH_WINDOW_TOP_ASSERT_SVH

// Same-cycle implication.
`define SOLW_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("solw assertion failed");

// Next-cycle implication.
`define SOLW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("solw assertion failed");

`endif

FILE: rtl/solw_pkg.sv
// ---------------------------------------------------------------------------
// Strapped output latch window package
// Codes, widths and the command and status bundles shared by the modules.
// ---------------------------------------------------------------------------
package solw_pkg;

  localparam int CFG_INDEX_W    = 1;
  localparam int CFG_DATA_W     = 6;
  localparam int IDENT_OFFSET_W = 6;
  localparam int PANEL_IDENT_W  = 2;

  localparam logic [CFG_INDEX_W-1:0] CFG_IDENT_OFFSET = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PANEL_IDENT  = 1'd1;

  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  localparam logic [1:0] WIDTH_BYTE    = 2'd0;
  localparam logic [1:0] WIDTH_HALF    = 2'd1;
  localparam logic [1:0] WIDTH_WORD    = 2'd2;
  localparam logic [1:0] WIDTH_ILLEGAL = 2'd3;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_ILLEGAL = 1'b1;

  typedef struct packed {
    logic load;
    logic clear_en;
    logic rd_en;
    logic merge;
  } solw_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic byte_last;
    logic start_illegal;
  } solw_stat_t;

  // Index of the last byte of an access, counted from zero.
  function automatic logic [1:0] last_byte_idx(input logic [1:0] code);
    logic [1:0] r;
    case (code)
      WIDTH_BYTE: r = 2'd0;
      WIDTH_HALF: r = 2'd1;
      WIDTH_WORD: r = 2'd3;
      default:    r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/solw_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module solw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/solw_ctrl.sv
// ---------------------------------------------------------------------------
// Strapped output latch window controller
// Sequences the clearing pass and the per-byte read and merge steps.
// ---------------------------------------------------------------------------
module solw_ctrl
  import solw_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  solw_stat_t stat,
  output solw_cmd_t  cmd,
  output logic       busy,
  output logic       done
);

  `include "strapped_output_latch_window_top_assert.svh"

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_READ, ST_MERGE} state_t;

  state_t state;

  always_comb begin
    cmd.load     = (state == ST_IDLE) && start;
    cmd.clear_en = (state == ST_CLEAR);
    cmd.rd_en    = (state == ST_READ);
    cmd.merge    = (state == ST_MERGE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      busy  <= 1'b1;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_CLEAR: begin
          if (stat.clear_last) begin
            state <= ST_IDLE;
            busy  <= 1'b0;
          end
        end
        ST_IDLE: begin
          if (start) begin
            if (stat.start_illegal) begin
              done <= 1'b1;
            end else begin
              state <= ST_READ;
              busy  <= 1'b1;
            end
          end
        end
        ST_READ: begin
          state <= ST_MERGE;
        end
        ST_MERGE: begin
          if (stat.byte_last) begin
            state <= ST_IDLE;
            busy  <= 1'b0;
            done  <= 1'b1;
          end else begin
            state <= ST_READ;
          end
        end
        default: begin
          state <= ST_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

  `SOLW_ASSERT_NOW(a_done_not_busy, done, !busy)
  `SOLW_ASSERT_NOW(a_busy_matches_state, busy, state != ST_IDLE)
  `SOLW_ASSERT_NEXT(a_illegal_done, start && !busy && stat.start_illegal, done && !busy)
  `SOLW_ASSERT_NEXT(a_legal_busy, start && !busy && !stat.start_illegal, busy && !done)
  `SOLW_ASSERT_NEXT(a_last_done, state == ST_MERGE && stat.byte_last, done)

endmodule

FILE: rtl/solw_dp.sv
// ---------------------------------------------------------------------------
// Strapped output latch window datapath
// Holds the request, the configuration, the latch RAM and the result.
// ---------------------------------------------------------------------------
module solw_dp
  import solw_pkg::*;
#(
  parameter int WINDOW_BYTES = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  solw_cmd_t              cmd,
  output solw_stat_t             stat,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   req_type,
  input  logic [31:0]            byte_offset,
  input  logic [1:0]             width_code,
  input  logic [31:0]            write_data,
  output logic [31:0]            read_data,
  output logic                   bus_status
);

  localparam int AW = (WINDOW_BYTES > 1) ? $clog2(WINDOW_BYTES) : 1;
  localparam int IDX_W = 33;

  logic [IDENT_OFFSET_W-1:0] ident_offset;
  logic [PANEL_IDENT_W-1:0]  panel_ident;
  logic                      is_write;
  logic [31:0]               base;
  logic [31:0]               wdata;
  logic [1:0]                cnt;
  logic [1:0]                last_idx;
  logic [AW-1:0]             clr_cnt;

  logic [IDX_W-1:0] idx;
  logic             in_win;
  logic             is_ident;
  logic [7:0]       rdata;
  logic [7:0]       rbyte;
  logic [7:0]       wbyte;
  logic [7:0]       wmerged;
  logic [1:0]       wsel;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [7:0]       ram_wdata;

  assign idx      = {1'b0, base} + {31'b0, cnt};
  assign in_win   = idx < IDX_W'(WINDOW_BYTES);
  assign is_ident = idx == IDX_W'(ident_offset);
  assign wsel     = last_idx - cnt;
  assign wbyte    = 8'(wdata >> {wsel, 3'b000});
  assign wmerged  = is_ident ? {wbyte[7:6], rdata[5:4], wbyte[3:0]} : wbyte;
  assign rbyte    = !in_win  ? 8'h00 :
                    is_ident ? {rdata[7:6], panel_ident, rdata[3:0]} : rdata;

  assign ram_we    = cmd.clear_en || (cmd.merge && is_write && in_win);
  assign ram_waddr = cmd.clear_en ? clr_cnt : idx[AW-1:0];
  assign ram_wdata = cmd.clear_en ? 8'h00 : wmerged;

  assign stat.clear_last    = clr_cnt == AW'(WINDOW_BYTES - 1);
  assign stat.byte_last     = cnt == last_idx;
  assign stat.start_illegal = width_code == WIDTH_ILLEGAL;

  solw_ram #(
    .WIDTH(8),
    .DEPTH(WINDOW_BYTES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (cmd.rd_en),
    .raddr(idx[AW-1:0]),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ident_offset <= '0;
      panel_ident  <= '0;
      clr_cnt      <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_IDENT_OFFSET: ident_offset <= cfg_data;
          CFG_PANEL_IDENT:  panel_ident  <= cfg_data[PANEL_IDENT_W-1:0];
          default: ;
        endcase
      end
      if (cmd.clear_en && !stat.clear_last) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      is_write   <= req_type == REQ_WRITE;
      base       <= byte_offset;
      wdata      <= write_data;
      cnt        <= 2'd0;
      last_idx   <= last_byte_idx(width_code);
      read_data  <= 32'h0;
      bus_status <= stat.start_illegal ? STATUS_ILLEGAL : STATUS_OK;
    end else if (cmd.merge) begin
      cnt <= cnt + 2'd1;
      if (!is_write) begin
        read_data <= {read_data[23:0], rbyte};
      end
    end
  end

endmodule

FILE: rtl/strapped_output_latch_window_top.sv
// ---------------------------------------------------------------------------
// Strapped output latch window
// Byte-wide output latches behind a bus with a strapped identifier field.
// ---------------------------------------------------------------------------
//
//   Channel   Handshake             Payload
//   request   start, busy           req_type, byte_offset, width_code, write_data
//   result    done (one cycle)      read_data, bus_status
//   config    cfg_we                cfg_index, cfg_data
//
// A legal access of n bytes steps through ST_READ and ST_MERGE for each
// byte before the next start: each byte needs a registered latch RAM read
// and then a merge step, since the single RAM write port serves one byte
// at a time. An illegal width gives done in the next cycle, staying idle.
// After reset a clearing pass over every latch byte holds busy high.
// The result receiver cannot stall; done lasts exactly one cycle.
// ---------------------------------------------------------------------------
module strapped_output_latch_window_top
  import solw_pkg::*;
#(
  parameter int WINDOW_BYTES = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic                   req_type,
  input  logic [31:0]            byte_offset,
  input  logic [1:0]             width_code,
  input  logic [31:0]            write_data,
  output logic                   done,
  output logic [31:0]            read_data,
  output logic                   bus_status,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  solw_cmd_t  cmd;
  solw_stat_t stat;

  solw_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .stat (stat),
    .cmd  (cmd),
    .busy (busy),
    .done (done)
  );

  solw_dp #(
    .WINDOW_BYTES(WINDOW_BYTES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .req_type   (req_type),
    .byte_offset(byte_offset),
    .width_code (width_code),
    .write_data (write_data),
    .read_data  (read_data),
    .bus_status (bus_status)
  );

endmodule

FILE: tb/sv/solw_access_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Access checker for the strapped output latch window
// Watches the request, result and configuration ports, keeps a shadow copy
// of the latch bytes and the strap registers, predicts the reply to every
// accepted access and compares each result with the oldest prediction.
// ---------------------------------------------------------------------------
module solw_access_checker
  import solw_pkg::*;
#(
  parameter int WINDOW_BYTES = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic                   busy,
  input  logic                   req_type,
  input  logic [31:0]            byte_offset,
  input  logic [1:0]             width_code,
  input  logic [31:0]            write_data,
  input  logic                   done,
  input  logic [31:0]            read_data,
  input  logic                   bus_status,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     mismatch_count,
  output int                     outstanding
);

  localparam int LAT_AW = (WINDOW_BYTES > 1) ? $clog2(WINDOW_BYTES) : 1;

  typedef struct packed {
    logic [31:0] data;
    logic        status;
  } bus_reply_t;

  logic [7:0]                shadow_latch [WINDOW_BYTES];
  logic [IDENT_OFFSET_W-1:0] strap_pos;
  logic [PANEL_IDENT_W-1:0]  strap_val;
  bus_reply_t                reply_queue [$];

  function automatic bus_reply_t predict_access(input logic rt, input logic [31:0] off,
                                                input logic [1:0] wc, input logic [31:0] wd);
    bus_reply_t  r;
    int unsigned nbytes;
    logic [32:0] pos;
    logic [7:0]  b;
    r.data   = '0;
    r.status = STATUS_OK;
    case (wc)
      WIDTH_BYTE: nbytes = 1;
      WIDTH_HALF: nbytes = 2;
      WIDTH_WORD: nbytes = 4;
      default:    nbytes = 0;
    endcase
    if (nbytes == 0) begin
      r.status = STATUS_ILLEGAL;
      return r;
    end
    for (int k = 0; k < nbytes; k++) begin
      pos = {1'b0, off} + 33'(k);
      if (rt == REQ_WRITE) begin
        if (pos < 33'(WINDOW_BYTES)) begin
          b = 8'(wd >> (8 * (nbytes - 1 - k)));
          if (pos == 33'(strap_pos)) begin
            b = (b & 8'hcf) | (shadow_latch[pos[LAT_AW-1:0]] & 8'h30);
          end
          shadow_latch[pos[LAT_AW-1:0]] = b;
        end
      end else begin
        b = 8'h00;
        if (pos < 33'(WINDOW_BYTES)) begin
          b = shadow_latch[pos[LAT_AW-1:0]];
          if (pos == 33'(strap_pos)) begin
            b = {b[7:6], strap_val, b[3:0]};
          end
        end
        r.data = {r.data[23:0], b};
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    bus_reply_t want;
    if (rst) begin
      for (int k = 0; k < WINDOW_BYTES; k++) begin
        shadow_latch[LAT_AW'(k)] = 8'h00;
      end
      strap_pos = '0;
      strap_val = '0;
      reply_queue.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_IDENT_OFFSET) begin
          strap_pos = cfg_data[IDENT_OFFSET_W-1:0];
        end else if (cfg_index == CFG_PANEL_IDENT) begin
          strap_val = cfg_data[PANEL_IDENT_W-1:0];
        end
      end
      if (start && !busy) begin
        reply_queue.push_back(predict_access(req_type, byte_offset, width_code, write_data));
      end
      if (done) begin
        if (reply_queue.size() == 0) begin
          report_mismatch("result with no transaction waiting", read_data, 32'h0);
        end else begin
          want = reply_queue.pop_front();
          if (read_data !== want.data) begin
            report_mismatch("read_data", read_data, want.data);
          end
          if (bus_status !== want.status) begin
            report_mismatch("bus_status", 32'(bus_status), 32'(want.status));
          end
        end
      end
    end
    outstanding = reply_queue.size();
  end

endmodule

FILE: tb/sv/tb_strapped_output_latch_window_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Testbench for the strapped output latch window
// Drives directed and random bus accesses under several strap settings,
// with random gaps between transactions outside one gapless phase, and lets the access checker
// predict and compare every result.
// ---------------------------------------------------------------------------
module tb_strapped_output_latch_window_top;
  import solw_pkg::*;

  localparam int WINDOW_BYTES = 64;

  logic                   clk         = 1'b0;
  logic                   rst         = 1'b1;
  logic                   start       = 1'b0;
  logic                   req_type    = REQ_READ;
  logic [31:0]            byte_offset = '0;
  logic [1:0]             width_code  = WIDTH_BYTE;
  logic [31:0]            write_data  = '0;
  logic                   cfg_we      = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index   = CFG_IDENT_OFFSET;
  logic [CFG_DATA_W-1:0]  cfg_data    = '0;
  logic                   busy;
  logic                   done;
  logic [31:0]            read_data;
  logic                   bus_status;
  int                     mismatch_count;
  int                     outstanding;

  logic                   gaps_on;
  logic [5:0]             cur_strap;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  strapped_output_latch_window_top #(
    .WINDOW_BYTES(WINDOW_BYTES)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .req_type   (req_type),
    .byte_offset(byte_offset),
    .width_code (width_code),
    .write_data (write_data),
    .done       (done),
    .read_data  (read_data),
    .bus_status (bus_status),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  solw_access_checker #(
    .WINDOW_BYTES(WINDOW_BYTES)
  ) u_checker (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .req_type      (req_type),
    .byte_offset   (byte_offset),
    .width_code    (width_code),
    .write_data    (write_data),
    .done          (done),
    .read_data     (read_data),
    .bus_status    (bus_status),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatch_count(mismatch_count),
    .outstanding   (outstanding)
  );

  task automatic send_access(input logic rt, input logic [31:0] off, input logic [1:0] wc,
                             input logic [31:0] wd);
    if (gaps_on) begin
      while ($urandom_range(0, 99) < 37) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start       <= 1'b1;
    req_type    <= rt;
    byte_offset <= off;
    width_code  <= wc;
    write_data  <= wd;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain_replies;
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0 || busy);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_strap(input logic [5:0] pos, input logic [1:0] val);
    drain_replies();
    set_reg(CFG_IDENT_OFFSET, pos);
    set_reg(CFG_PANEL_IDENT, CFG_DATA_W'(val));
    cur_strap = pos;
    @(posedge clk);
  endtask

  initial begin
    int unsigned sel;
    logic [31:0] off;
    logic [1:0]  wc;
    logic [5:0]  pos;
    logic [1:0]  val;
    gaps_on   = 1'b1;
    cur_strap = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed transactions under the reset strap setting.
    send_access(REQ_READ,  32'd0,          WIDTH_WORD,    32'h0);
    send_access(REQ_WRITE, 32'd0,          WIDTH_WORD,    32'hffff_ffff);
    send_access(REQ_READ,  32'd0,          WIDTH_WORD,    32'h0);
    send_access(REQ_WRITE, 32'd4,          WIDTH_HALF,    32'h1234_a55a);
    send_access(REQ_READ,  32'd4,          WIDTH_WORD,    32'hffff_ffff);
    send_access(REQ_READ,  32'd5,          WIDTH_BYTE,    32'h0);
    send_access(REQ_WRITE, 32'd62,         WIDTH_WORD,    32'h1122_3344);
    send_access(REQ_READ,  32'd60,         WIDTH_WORD,    32'h0);
    send_access(REQ_READ,  32'd63,         WIDTH_HALF,    32'h0);
    send_access(REQ_READ,  32'd64,         WIDTH_BYTE,    32'h0);
    send_access(REQ_WRITE, 32'hffff_fffe,  WIDTH_WORD,    32'hdead_beef);
    send_access(REQ_READ,  32'hffff_fffd,  WIDTH_WORD,    32'h0);
    send_access(REQ_WRITE, 32'd0,          WIDTH_ILLEGAL, 32'h0000_0000);
    send_access(REQ_READ,  32'd0,          WIDTH_ILLEGAL, 32'hffff_ffff);
    send_access(REQ_READ,  32'hffff_ffff,  WIDTH_ILLEGAL, 32'h0);

    // Strap moved to the last byte of the window at its highest identifier.
    set_strap(6'd63, 2'd3);
    send_access(REQ_READ,  32'd60,         WIDTH_WORD,    32'h0);
    send_access(REQ_WRITE, 32'd63,         WIDTH_BYTE,    32'h0000_0000);
    send_access(REQ_READ,  32'd63,         WIDTH_BYTE,    32'h0);
    send_access(REQ_READ,  32'd0,          WIDTH_WORD,    32'h0);
    send_access(REQ_WRITE, 32'd0,          WIDTH_BYTE,    32'h0000_00ff);
    send_access(REQ_READ,  32'd0,          WIDTH_BYTE,    32'h0);
    send_access(REQ_WRITE, 32'd63,         WIDTH_BYTE,    32'h0000_00ff);
    send_access(REQ_READ,  32'd62,         WIDTH_HALF,    32'h0);

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       begin pos = 6'd0;  val = 2'd3; end
        1:       begin pos = 6'd63; val = 2'd0; end
        4:       begin pos = 6'd31; val = 2'd2; end
        default: begin pos = 6'($urandom_range(0, 63)); val = 2'($urandom_range(0, 3)); end
      endcase
      set_strap(pos, val);
      gaps_on = (phase != 1);
      for (int n = 0; n < 133; n++) begin
        if (phase == 3 && n == 66) begin
          drain_replies();
        end
        sel = $urandom_range(0, 99);
        if (sel < 60) begin
          off = 32'($urandom_range(0, 63));
        end else if (sel < 75) begin
          off = 32'(cur_strap) - 32'($urandom_range(0, 3));
        end else if (sel < 88) begin
          off = 32'($urandom_range(56, 72));
        end else begin
          off = $urandom();
        end
        wc = ($urandom_range(0, 99) < 10) ? WIDTH_ILLEGAL : 2'($urandom_range(0, 2));
        send_access(1'($urandom_range(0, 1)), off, wc, $urandom());
      end
    end

    drain_replies();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
